[hdl/pid_controller_antiwindup_top_defines.svh]
// ---------------------------------------------------------------------------
// pid controller assertion macros
// shared property wrappers, clocked on clock and held off during reset
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH

// same-cycle implication
`define PIDAW_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define PIDAW_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hdl/pidaw_pkg.sv]
// ---------------------------------------------------------------------------
// pid controller package
// widths, register indexes, reset values and the word types between stages
// ---------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int ERR_W     = 17;
   localparam int DERR_W    = 18;
   localparam int GAIN_W    = 16;
   localparam int DATA_W    = 32;
   localparam int LIMIT_W   = 31;
   localparam int CSR_IDX_W = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int OUT_DEPTH   = 8;
   localparam int OPTR_W      = 3;
   localparam int OCNT_W      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TERM_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ISTEP_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ISTEP_MIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MIN    = 3'd7;

   typedef struct packed {
      logic                     clear;
      logic signed [ERR_W-1:0]  err;
      logic signed [DERR_W-1:0] derr;
   } pidaw_item_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic        [LIMIT_W-1:0] term_limit;
      logic signed [DATA_W-1:0] istep_max;
      logic signed [DATA_W-1:0] istep_min;
      logic signed [DATA_W-1:0] out_max;
      logic signed [DATA_W-1:0] out_min;
   } pidaw_cfg_type;

   localparam pidaw_cfg_type CFG_RESET = '{
      gain_p:     16'sd256,
      gain_i:     16'sd0,
      gain_d:     16'sd0,
      term_limit: 31'h7FFF_FFFF,
      istep_max:  32'sh7FFF_FFFF,
      istep_min:  32'sh8000_0000,
      out_max:    32'sh7FFF_FFFF,
      out_min:    32'sh8000_0000
   };

endpackage

`default_nettype wire

[hdl/pidaw_csr.sv]
// ---------------------------------------------------------------------------
// pid controller register file
// write-only gain and limit registers, loaded from the plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module pidaw_csr
   import pidaw_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata,
   output pidaw_cfg_type             cfg
);

   pidaw_cfg_type cfg_ff;
   pidaw_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAIN_P:     cfg_in.gain_p     = csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i     = csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d     = csr_wdata[GAIN_W-1:0];
            REG_TERM_LIMIT: cfg_in.term_limit = csr_wdata[LIMIT_W-1:0];
            REG_ISTEP_MAX:  cfg_in.istep_max  = csr_wdata;
            REG_ISTEP_MIN:  cfg_in.istep_min  = csr_wdata;
            REG_OUT_MAX:    cfg_in.out_max    = csr_wdata;
            REG_OUT_MIN:    cfg_in.out_min    = csr_wdata;
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/pidaw_front.sv]
// ---------------------------------------------------------------------------
// pid controller front end
// accepts samples, forms error and error delta, sorts out clear commands
// ---------------------------------------------------------------------------
`default_nettype none

module pidaw_front
   import pidaw_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic                       req_command,
   input  wire logic signed [SAMPLE_W-1:0] req_target,
   input  wire logic signed [SAMPLE_W-1:0] req_actual,
   input  wire logic                       q_full,
   output logic                            q_push,
   output pidaw_item_type                  q_item
);

   logic signed [ERR_W-1:0]  prev_err_ff;
   logic signed [ERR_W-1:0]  prev_err_in;
   logic signed [ERR_W-1:0]  err;
   logic signed [DERR_W-1:0] derr;
   logic                     accept;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;
   assign q_push   = accept;

   assign err  = $signed({req_target[SAMPLE_W-1], req_target})
               - $signed({req_actual[SAMPLE_W-1], req_actual});
   assign derr = $signed({err[ERR_W-1], err}) - $signed({prev_err_ff[ERR_W-1], prev_err_ff});

   // a clear word carries zero operands, the back end only looks at the flag
   always_comb begin
      q_item.clear = req_command;
      q_item.err   = req_command ? '0 : err;
      q_item.derr  = req_command ? '0 : derr;
      prev_err_in  = prev_err_ff;
      if (accept) begin
         prev_err_in = req_command ? '0 : err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
      end else begin
         prev_err_ff <= prev_err_in;
      end
   end

endmodule

`default_nettype wire

[hdl/pidaw_queue.sv]
// ---------------------------------------------------------------------------
// pid controller work queue
// short first-in first-out buffer between front end and back end
// ---------------------------------------------------------------------------
`default_nettype none
`include "pid_controller_antiwindup_top_defines.svh"

module pidaw_queue
   import pidaw_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire pidaw_item_type push_item,
   output logic                full,
   input  wire logic           pop,
   output pidaw_item_type      pop_item,
   output logic                empty
);

   pidaw_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff;
   logic [QPTR_W-1:0]      wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff;
   logic [QPTR_W-1:0]      rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff;
   logic [QCNT_W-1:0]      count_in;
   logic                   do_push;
   logic                   do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PIDAW_ASSERT_NOW(a_queue_no_overrun, push, !full, "queue push while full")
   `PIDAW_ASSERT_NOW(a_queue_no_underrun, pop, !empty, "queue pop while empty")

endmodule

`default_nettype wire

[hdl/pidaw_back.sv]
// ---------------------------------------------------------------------------
// pid controller back end
// product, clamp and sum pipeline with integral state and result buffer
// ---------------------------------------------------------------------------
`default_nettype none
`include "pid_controller_antiwindup_top_defines.svh"

module pidaw_back
   import pidaw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pidaw_cfg_type            cfg,
   input  wire logic                     q_empty,
   input  wire pidaw_item_type           q_item,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output logic signed [DATA_W-1:0]      rsp_drive,
   output logic                          rsp_saturated
);

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     saturated;
   } pidaw_result_type;

   // issue control
   logic [1:0]        inflight;
   logic [OCNT_W-1:0] occupancy;
   logic              issue;

   // stage 1: products
   logic                       v1_ff;
   logic                       clr1_ff;
   logic signed [32:0]         prod_p1_ff;
   logic signed [33:0]         prod_d1_ff;
   logic signed [32:0]         prod_i1_ff;
   logic                       gi_zero1_ff;

   // stage 2: shifted and clamped terms
   logic                       v2_ff;
   logic                       clr2_ff;
   logic signed [DATA_W-1:0]   p2_ff;
   logic signed [DATA_W-1:0]   d2_ff;
   logic signed [DATA_W-1:0]   i2_ff;
   logic signed [DATA_W-1:0]   p2_in;
   logic signed [DATA_W-1:0]   d2_in;
   logic signed [DATA_W-1:0]   i2_in;

   // stage 3: term sum
   logic                       v3_ff;
   logic                       clr3_ff;
   logic signed [33:0]         pdi3_ff;
   logic signed [DATA_W-1:0]   ist3_ff;

   // integral state and output saturation
   logic signed [DATA_W-1:0]   acc_ff;
   logic signed [DATA_W-1:0]   acc_in;
   logic signed [34:0]         sum4;
   logic signed [34:0]         sat_sum4;
   logic signed [DATA_W-1:0]   ist_eff4;
   logic signed [32:0]         acc_next4;
   logic                       sat4;
   logic signed [DATA_W-1:0]   drive4;
   pidaw_result_type           result4;

   // result buffer
   pidaw_result_type           out_mem_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]          out_wr_ff;
   logic [OPTR_W-1:0]          out_wr_in;
   logic [OPTR_W-1:0]          out_rd_ff;
   logic [OPTR_W-1:0]          out_rd_in;
   logic [OCNT_W-1:0]          out_count_ff;
   logic [OCNT_W-1:0]          out_count_in;
   logic                       out_pop;

   // a word enters only when a buffer slot is certain to be free at its end
   assign inflight  = 2'({1'b0, v1_ff} + {1'b0, v2_ff} + {1'b0, v3_ff});
   assign occupancy = out_count_ff + OCNT_W'(inflight);
   assign issue     = ~q_empty & (occupancy < OCNT_W'(OUT_DEPTH));
   assign q_pop     = issue;

   // stage 2 clamps
   always_comb begin
      logic signed [32:0] lim;
      logic signed [32:0] nlim;
      logic signed [32:0] p_ext;
      logic signed [32:0] d_ext;
      logic signed [32:0] i_ext;
      logic signed [32:0] ihi;
      logic signed [32:0] ilo;
      lim   = $signed({2'b00, cfg.term_limit});
      nlim  = -lim;
      p_ext = $signed({{8{prod_p1_ff[32]}}, prod_p1_ff[32:8]});
      d_ext = $signed({{7{prod_d1_ff[33]}}, prod_d1_ff[33:8]});
      i_ext = $signed({{8{prod_i1_ff[32]}}, prod_i1_ff[32:8]});
      ihi   = $signed({cfg.istep_max[DATA_W-1], cfg.istep_max});
      ilo   = $signed({cfg.istep_min[DATA_W-1], cfg.istep_min});
      if (p_ext > lim) begin
         p_ext = lim;
      end
      if (p_ext < nlim) begin
         p_ext = nlim;
      end
      if (d_ext > lim) begin
         d_ext = lim;
      end
      if (d_ext < nlim) begin
         d_ext = nlim;
      end
      // upper bound first, so a crossed lower bound wins
      if (i_ext > ihi) begin
         i_ext = ihi;
      end
      if (i_ext < ilo) begin
         i_ext = ilo;
      end
      p2_in = p_ext[DATA_W-1:0];
      d2_in = d_ext[DATA_W-1:0];
      i2_in = gi_zero1_ff ? '0 : i_ext[DATA_W-1:0];
   end

   // output saturation and anti-windup
   always_comb begin
      logic signed [34:0] hi;
      logic signed [34:0] lo;
      logic signed [32:0] amax;
      logic signed [32:0] amin;
      hi       = $signed({{3{cfg.out_max[DATA_W-1]}}, cfg.out_max});
      lo       = $signed({{3{cfg.out_min[DATA_W-1]}}, cfg.out_min});
      amax     = $signed({2'b00, {(DATA_W-1){1'b1}}});
      amin     = $signed({2'b11, {(DATA_W-1){1'b0}}});
      sum4     = $signed({{3{acc_ff[DATA_W-1]}}, acc_ff}) + $signed({pdi3_ff[33], pdi3_ff});
      sat_sum4 = sum4;
      sat4     = 1'b0;
      ist_eff4 = ist3_ff;
      if (sat_sum4 > hi) begin
         sat_sum4 = hi;
         sat4     = 1'b1;
         if (ist3_ff > 0) begin
            ist_eff4 = '0;
         end
      end
      if (sat_sum4 < lo) begin
         sat_sum4 = lo;
         sat4     = 1'b1;
         if (ist3_ff < 0) begin
            ist_eff4 = '0;
         end
      end
      drive4    = sat_sum4[DATA_W-1:0];
      acc_next4 = $signed({acc_ff[DATA_W-1], acc_ff}) + $signed({ist_eff4[DATA_W-1], ist_eff4});
      if (acc_next4 > amax) begin
         acc_next4 = amax;
      end
      if (acc_next4 < amin) begin
         acc_next4 = amin;
      end
      acc_in = acc_ff;
      result4.drive     = drive4;
      result4.saturated = sat4;
      if (v3_ff) begin
         if (clr3_ff) begin
            acc_in            = '0;
            result4.drive     = '0;
            result4.saturated = 1'b0;
         end else begin
            acc_in = acc_next4[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      clr1_ff     <= q_item.clear;
      prod_p1_ff  <= q_item.err * cfg.gain_p;
      prod_d1_ff  <= q_item.derr * cfg.gain_d;
      prod_i1_ff  <= q_item.err * cfg.gain_i;
      gi_zero1_ff <= (cfg.gain_i == '0);
      clr2_ff     <= clr1_ff;
      p2_ff       <= p2_in;
      d2_ff       <= d2_in;
      i2_ff       <= i2_in;
      clr3_ff     <= clr2_ff;
      pdi3_ff     <= $signed({{2{p2_ff[DATA_W-1]}}, p2_ff}) + $signed({{2{d2_ff[DATA_W-1]}}, d2_ff})
                   + $signed({{2{i2_ff[DATA_W-1]}}, i2_ff});
      ist3_ff     <= i2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff  <= issue;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         acc_ff <= acc_in;
      end
   end

   // result buffer
   assign rsp_empty     = (out_count_ff == '0);
   assign out_pop       = rsp_pop & ~rsp_empty;
   assign rsp_drive     = out_mem_ff[out_rd_ff].drive;
   assign rsp_saturated = out_mem_ff[out_rd_ff].saturated;

   always_comb begin
      out_wr_in    = v3_ff   ? out_wr_ff + OPTR_W'(1) : out_wr_ff;
      out_rd_in    = out_pop ? out_rd_ff + OPTR_W'(1) : out_rd_ff;
      out_count_in = out_count_ff;
      if (v3_ff && !out_pop) begin
         out_count_in = out_count_ff + OCNT_W'(1);
      end else if (out_pop && !v3_ff) begin
         out_count_in = out_count_ff - OCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         out_mem_ff[out_wr_ff] <= result4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   `PIDAW_ASSERT_NOW(a_back_credit, 1'b1, occupancy <= OCNT_W'(OUT_DEPTH), "result buffer overbooked")
   `PIDAW_ASSERT_NEXT(a_back_clear, v3_ff && clr3_ff, acc_ff == '0, "clear left integral nonzero")
   `PIDAW_ASSERT_NOW(a_back_in_range, v3_ff && !clr3_ff && !sat4,
      (drive4 <= cfg.out_max) && (drive4 >= cfg.out_min), "unsaturated drive outside limits")

endmodule

`default_nettype wire

[hdl/pid_controller_antiwindup_top.sv]
// ---------------------------------------------------------------------------
// pid controller with anti-windup, top level
// Input queue side: drive req_command, req_target and req_actual with
// req_push; a word is taken at a clock edge where req_push is high and
// req_full is low. Command 0 runs one control step, command 1 clears the
// stored error and integral and returns drive 0, saturated 0.
// Result queue side: while rsp_empty is low the oldest result sits on
// rsp_drive and rsp_saturated; it is taken at an edge with rsp_pop high.
// Every word gives exactly one result, in order.
// A word passes through the work queue, then products, clamps and term sum,
// with the integral update and output saturation in the last step.
// Throughput: one word per cycle while results are taken; the integral update
// loop sets that figure. When rsp_pop stays low the 8-entry result buffer
// fills, the back end stops pulling from the 4-entry work queue and req_full
// rises. Registers are loaded through csr_write, csr_index, csr_wdata, one
// per cycle, while the block is idle; the user must keep to that, the block
// does not enforce it. Reset (synchronous) loads register defaults, clears
// the state and empties both queues.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_antiwindup_top
   import pidaw_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic                       req_command,
   input  wire logic signed [SAMPLE_W-1:0] req_target,
   input  wire logic signed [SAMPLE_W-1:0] req_actual,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic signed [DATA_W-1:0]        rsp_drive,
   output logic                            rsp_saturated,
   input  wire logic                       csr_write,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [DATA_W-1:0]          csr_wdata
);

   pidaw_cfg_type  cfg;
   pidaw_item_type push_item;
   pidaw_item_type pop_item;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   pidaw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidaw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_command (req_command),
      .req_target  (req_target),
      .req_actual  (req_actual),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   pidaw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   pidaw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_empty       (q_empty),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_drive     (rsp_drive),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid controller with anti-windup, block-level testbench
// Drives control steps and clear words into the input queue, keeps its own
// fixed-point model of the error, derivative and integral paths and checks
// every drive/saturated result in order. Covers gain and limit extremes,
// crossed clamps, integrator rail hits, random settings with bursty input,
// random result stalls and one long hold-off that backs up the input queue.
// ---------------------------------------------------------------------------

module testbench;
   import pidaw_pkg::*;

   typedef enum logic {
      CMD_RUN   = 1'b0,
      CMD_CLEAR = 1'b1
   } pid_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     saturated;
   } drive_result_type;

   localparam longint ACC_TOP       = 64'sd2147483647;
   localparam longint ACC_BOTTOM    = -64'sd2147483648;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     RAIL_STEPS    = 330;
   localparam int     PHASE_COUNT   = 12;
   localparam int     PHASE_WORDS   = 100;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic                       req_command = 1'b0;
   logic signed [SAMPLE_W-1:0] req_target = '0;
   logic signed [SAMPLE_W-1:0] req_actual = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [DATA_W-1:0]   rsp_drive;
   logic                       rsp_saturated;
   logic                       csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [DATA_W-1:0]          csr_wdata = '0;

   // model copy of the registers and the controller state
   pidaw_cfg_type live_cfg = CFG_RESET;
   longint        held_err = 0;
   longint        integ_acc = 0;

   drive_result_type drive_due[$];

   int error_count = 0;
   int words_sent = 0;
   int results_checked = 0;
   int saturated_seen = 0;
   int settings_loaded = 0;
   int full_stalls = 0;
   int hold_stalls = 0;
   int rail_hits = 0;
   int burst_left = 0;
   int hold_request = 0;
   int hold_left = 0;
   logic [15:0] stall_mask = '0;
   logic [3:0]  pat_pos = '0;

   pid_controller_antiwindup_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_target    (req_target),
      .req_actual    (req_actual),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_drive     (rsp_drive),
      .rsp_saturated (rsp_saturated),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < 40)
         $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic longint clamp_range(input longint v, input longint hi, input longint lo);
      if (v > hi)
         v = hi;
      if (v < lo)
         v = lo;
      return v;
   endfunction

   // one control step of the model; updates held_err and integ_acc
   function automatic drive_result_type predict_drive(input pid_cmd_type cmd,
                                                      input logic signed [SAMPLE_W-1:0] tgt,
                                                      input logic signed [SAMPLE_W-1:0] act);
      longint err, lim, p_term, d_term, i_step, total, omax, omin, next_acc;
      drive_result_type res;
      res.drive = '0;
      res.saturated = 1'b0;
      if (cmd == CMD_CLEAR) begin
         held_err = 0;
         integ_acc = 0;
         return res;
      end
      lim = longint'(live_cfg.term_limit);
      omax = longint'($signed(live_cfg.out_max));
      omin = longint'($signed(live_cfg.out_min));
      err = longint'(tgt) - longint'(act);
      // gains are Q8.8, so products are shifted down by 8 with floor rounding
      p_term = clamp_range((err * longint'($signed(live_cfg.gain_p))) >>> 8, lim, -lim);
      d_term = clamp_range(((err - held_err) * longint'($signed(live_cfg.gain_d))) >>> 8,
                           lim, -lim);
      i_step = 0;
      if (live_cfg.gain_i != 0)
         i_step = clamp_range((err * longint'($signed(live_cfg.gain_i))) >>> 8,
                              longint'($signed(live_cfg.istep_max)),
                              longint'($signed(live_cfg.istep_min)));
      total = integ_acc + p_term + d_term + i_step;
      // upper limit first, then lower; a step pushing further into the limit is dropped
      if (total > omax) begin
         total = omax;
         res.saturated = 1'b1;
         if (i_step > 0)
            i_step = 0;
      end
      if (total < omin) begin
         total = omin;
         res.saturated = 1'b1;
         if (i_step < 0)
            i_step = 0;
      end
      held_err = err;
      next_acc = integ_acc + i_step;
      if (next_acc > ACC_TOP || next_acc < ACC_BOTTOM)
         rail_hits++;
      integ_acc = clamp_range(next_acc, ACC_TOP, ACC_BOTTOM);
      res.drive = total[DATA_W-1:0];
      return res;
   endfunction

   // called at a rising edge; returns at the edge that takes the word
   task automatic send_word(input pid_cmd_type cmd, input logic signed [SAMPLE_W-1:0] tgt,
                            input logic signed [SAMPLE_W-1:0] act);
      logic taken;
      req_push <= 1'b1;
      req_command <= cmd;
      req_target <= tgt;
      req_actual <= act;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_full;
         if (!taken) begin
            full_stalls++;
            if (hold_left != 0)
               hold_stalls++;
         end
         @(posedge clock);
      end
      drive_due.push_back(predict_drive(cmd, tgt, act));
      words_sent++;
   endtask

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (drive_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // unused upper bits of the narrow registers get random filler
   task automatic load_settings(input pidaw_cfg_type s);
      settle();
      write_reg(REG_GAIN_P, {16'($urandom), s.gain_p});
      write_reg(REG_GAIN_I, {16'($urandom), s.gain_i});
      write_reg(REG_GAIN_D, {16'($urandom), s.gain_d});
      write_reg(REG_TERM_LIMIT, {1'($urandom), s.term_limit});
      write_reg(REG_ISTEP_MAX, s.istep_max);
      write_reg(REG_ISTEP_MIN, s.istep_min);
      write_reg(REG_OUT_MAX, s.out_max);
      write_reg(REG_OUT_MIN, s.out_min);
      csr_write <= 1'b0;
      live_cfg = s;
      settings_loaded++;
   endtask

   function automatic logic signed [GAIN_W-1:0] pick_gain();
      logic signed [GAIN_W-1:0] g;
      case ($urandom_range(0, 6))
         0: g = 16'sh8000;
         1: g = 16'sh7FFF;
         2: g = '0;
         3: g = 16'(int'($urandom_range(0, 1024)) - 512);
         default: g = 16'($urandom);
      endcase
      return g;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_bound();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 32'sh7FFF_FFFF;
         1: v = 32'sh8000_0000;
         default: begin
            v = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic pidaw_cfg_type random_settings();
      pidaw_cfg_type s;
      logic signed [DATA_W-1:0] hi, lo, t;
      s.gain_p = pick_gain();
      s.gain_i = pick_gain();
      s.gain_d = pick_gain();
      case ($urandom_range(0, 3))
         0: s.term_limit = '1;
         1: s.term_limit = '0;
         default: s.term_limit = 31'($urandom >> $urandom_range(1, 31));
      endcase
      // mostly ordered limit pairs, crossed now and then
      hi = pick_bound();
      lo = pick_bound();
      if (hi < lo && $urandom_range(0, 5) != 0) begin
         t = hi;
         hi = lo;
         lo = t;
      end
      s.istep_max = hi;
      s.istep_min = lo;
      hi = pick_bound();
      lo = pick_bound();
      if (hi < lo && $urandom_range(0, 5) != 0) begin
         t = hi;
         hi = lo;
         lo = t;
      end
      s.out_max = hi;
      s.out_min = lo;
      return s;
   endfunction

   // result side: random stall pattern, or a long hold when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_request != 0 || hold_left != 0) begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         if (pat_pos == 0) begin
            case ($urandom_range(0, 3))
               0: stall_mask = '0;
               1: stall_mask = 16'($urandom);
               default: stall_mask = 16'($urandom & $urandom);
            endcase
         end
         rsp_pop <= !stall_mask[pat_pos];
         pat_pos = pat_pos + 1'b1;
      end
   end

   // result check, sampled between edges
   always @(negedge clock) begin
      drive_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (drive_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: drive %0d sat %0b",
                                      rsp_drive, rsp_saturated));
         end else begin
            want = drive_due.pop_front();
            results_checked++;
            if (want.saturated)
               saturated_seen++;
            if (rsp_drive !== want.drive)
               report_mismatch($sformatf("drive %0d, expected %0d", rsp_drive,
                                         $signed(want.drive)));
            if (rsp_saturated !== want.saturated)
               report_mismatch($sformatf("saturated %0b, expected %0b", rsp_saturated,
                                         want.saturated));
         end
      end
   end

   task automatic test_reset_defaults();
      send_word(CMD_RUN, 16'sh7FFF, 16'sh8000);
      send_word(CMD_RUN, 16'sh8000, 16'sh7FFF);
      send_word(CMD_RUN, 16'sd0, 16'sd0);
      send_word(CMD_CLEAR, 16'sh7FFF, 16'sh7FFF);
      send_word(CMD_RUN, -16'sd1, 16'sd0);
   endtask

   task automatic test_gain_extremes();
      pidaw_cfg_type s;
      s = CFG_RESET;
      s.gain_p = 16'sh8000;
      s.gain_i = 16'sh7FFF;
      s.gain_d = 16'sh8000;
      load_settings(s);
      // full-scale error swings give the largest derivative
      send_word(CMD_RUN, 16'sh7FFF, 16'sh8000);
      send_word(CMD_RUN, 16'sh8000, 16'sh7FFF);
      send_word(CMD_RUN, 16'sh7FFF, 16'sh8000);
      send_word(CMD_CLEAR, 16'($urandom), 16'($urandom));
      s.gain_p = 16'sh7FFF;
      s.gain_i = 16'sh8000;
      s.gain_d = 16'sh7FFF;
      load_settings(s);
      send_word(CMD_RUN, 16'sh8000, 16'sh7FFF);
      send_word(CMD_RUN, 16'sh7FFF, 16'sh8000);
   endtask

   task automatic test_term_and_istep_clamps();
      pidaw_cfg_type s;
      s = CFG_RESET;
      s.gain_p = 16'sh7FFF;
      s.gain_d = 16'sh7FFF;
      s.gain_i = 16'sd256;
      s.term_limit = '0;
      load_settings(s);
      send_word(CMD_RUN, 16'sd1000, -16'sd1000);
      send_word(CMD_RUN, -16'sd1000, 16'sd1000);
      // crossed step clamps: the lower one wins
      s.term_limit = 31'd100000;
      s.istep_max = -32'sd5000;
      s.istep_min = 32'sd5000;
      load_settings(s);
      send_word(CMD_RUN, 16'sd2000, 16'sd0);
      send_word(CMD_RUN, -16'sd2000, 16'sd0);
      // zero integral gain gives no step even with crossed clamps
      s.gain_i = '0;
      load_settings(s);
      send_word(CMD_RUN, 16'sd2000, 16'sd0);
   endtask

   task automatic test_output_limits();
      pidaw_cfg_type s;
      s = CFG_RESET;
      s.gain_i = 16'sd256;
      s.out_max = 32'sd1000;
      s.out_min = -32'sd1000;
      load_settings(s);
      send_word(CMD_CLEAR, 16'sd0, 16'sd0);
      send_word(CMD_RUN, 16'sd5000, 16'sd0);
      send_word(CMD_RUN, -16'sd5000, 16'sd0);
      send_word(CMD_RUN, 16'sd300, 16'sd0);
      // crossed output limits end on out_min
      s.out_max = -32'sd700;
      s.out_min = 32'sd700;
      load_settings(s);
      send_word(CMD_RUN, 16'sd100, 16'sd0);
      send_word(CMD_RUN, -16'sd100, 16'sd0);
   endtask

   // sustained one-sided error with P opposing I so the integrator runs into its rail
   task automatic test_integral_rail();
      pidaw_cfg_type s;
      int ki;
      s = CFG_RESET;
      ki = $urandom_range(28000, 30000);
      s.gain_i = 16'(ki);
      s.gain_p = 16'(-ki - int'($urandom_range(512, 2768)));
      s.gain_d = 16'(int'($urandom_range(0, 128)) - 64);
      load_settings(s);
      for (int dir = 0; dir < 2; dir++) begin
         send_word(CMD_CLEAR, 16'($urandom), 16'($urandom));
         repeat (RAIL_STEPS) begin
            if (dir == 0)
               send_word(CMD_RUN, 16'($urandom_range(30000, 32767)),
                         16'(-int'($urandom_range(30000, 32768))));
            else
               send_word(CMD_RUN, 16'(-int'($urandom_range(30000, 32768))),
                         16'($urandom_range(30000, 32767)));
            pace_sender();
         end
      end
   endtask

   // plant-like trajectories with noise words and occasional clears
   task automatic run_control_phase(input int count, input bit steady);
      int tgt_i, act_i, pick;
      tgt_i = int'($urandom_range(0, 65535)) - 32768;
      act_i = int'($urandom_range(0, 65535)) - 32768;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_word(CMD_CLEAR, 16'($urandom), 16'($urandom));
         end else if (pick < 20) begin
            send_word(CMD_RUN, 16'($urandom), 16'($urandom));
         end else begin
            if ($urandom_range(0, 24) == 0) begin
               case ($urandom_range(0, 3))
                  0: tgt_i = 32767;
                  1: tgt_i = -32768;
                  default: tgt_i = int'($urandom_range(0, 65535)) - 32768;
               endcase
            end
            act_i = act_i + (tgt_i - act_i) / 4 + int'($urandom_range(0, 64)) - 32;
            act_i = int'(clamp_range(longint'(act_i), 32767, -32768));
            send_word(CMD_RUN, 16'(tgt_i), 16'(act_i));
         end
         if (!steady)
            pace_sender();
      end
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         load_settings(random_settings());
         run_control_phase(PHASE_WORDS, $urandom_range(0, 3) == 0);
      end
   endtask

   // result side holds off while words keep coming, so the queues back up
   task automatic test_backpressure();
      load_settings(random_settings());
      @(negedge clock);
      hold_request = 200;
      @(posedge clock);
      run_control_phase(48, 1'b1);
   endtask

   initial begin
      int drain;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_gain_extremes();
      test_term_and_istep_clamps();
      test_output_limits();
      test_integral_rail();
      test_backpressure();
      test_random_phases();
      req_push <= 1'b0;
      drain = 0;
      while (drive_due.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (drive_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", drive_due.size()));
      $display("run covered %0d words, %0d results checked, %0d of them saturated",
               words_sent, results_checked, saturated_seen);
      $display("%0d register sets, %0d integrator rail hits, %0d full cycles (%0d in hold-off)",
               settings_loaded, rail_hits, full_stalls, hold_stalls);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", drive_due.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/pidaw_pkg.sv
hdl/pidaw_csr.sv
hdl/pidaw_front.sv
hdl/pidaw_queue.sv
hdl/pidaw_back.sv
hdl/pid_controller_antiwindup_top.sv
verif/testbench.sv
